FILE: hdl/x86ex_pkg.sv
// ----------------------------------------------------------------------------
// x86ex_pkg: shared types and constants of the 16-bit execute unit
// Opcodes, operand kinds, sequencer states and the packed item layouts.
// ----------------------------------------------------------------------------
package x86ex_pkg;

	// Default size of the data memory in bytes.
	localparam int DEFAULT_MEM_BYTES = 1024 * 64;

	// Width of the stream payloads, padded to whole bytes.
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 40;
	localparam int RESULT_W    = 36;

	// Operation codes; the codes above OP_NOP behave like OP_NOP.
	typedef enum logic [2:0] {
		OP_MOV = 3'd0,
		OP_ADD = 3'd1,
		OP_SUB = 3'd2,
		OP_CMP = 3'd3,
		OP_JNE = 3'd4,
		OP_NOP = 3'd5
	} op_t;

	// Operand kinds.
	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_REG  = 2'd1,
		KIND_MEM  = 2'd2,
		KIND_IMM  = 2'd3
	} kind_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADDR,
		ST_OPER,
		ST_EXEC
	} state_t;

	// One decoded instruction; the first field sits in the highest bits.
	typedef struct packed {
		logic [2:0]  instr_length;
		logic [15:0] disp_value;
		logic [3:0]  index_term;
		logic [3:0]  base_term;
		logic [15:0] imm_value;
		logic [2:0]  src_reg;
		logic [1:0]  src_kind;
		logic [2:0]  dst_reg;
		logic [1:0]  dst_kind;
		logic [2:0]  op;
	} item_t;

	// One result; the first field sits in the highest bits.
	typedef struct packed {
		logic        parity_flag;
		logic        sign_flag;
		logic        zero_flag;
		logic        jump_taken;
		logic [15:0] result_value;
		logic [15:0] next_ip;
	} result_t;

endpackage

FILE: hdl/x86ex_ram.sv
// ----------------------------------------------------------------------------
// x86ex_ram: generic synchronous RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module x86ex_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read share the clock edge.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hdl/x86_16bit_execute_subset_unit.sv
// ----------------------------------------------------------------------------
// x86_16bit_execute_subset_unit: execute stage of a 16-bit x86 subset
// Runs mov, add, sub, cmp and jne on eight word registers and a byte memory.
// ----------------------------------------------------------------------------
// Usage:
// The s_* stream carries one decoded instruction per transaction; the m_*
// stream returns one result per instruction, in order.
// Each instruction makes three passes over the state memories: the address
// registers are read, then the operand registers and the memory word, then the
// result is computed and written back. The register file is a pair of 8x16
// RAMs written together, the data memory two byte banks (even and odd
// addresses) so that any unaligned word is one row in each bank.
// A new input is buffered while one executes, so the unit accepts the next
// instruction before it is through with the last; each instruction still
// completes only after its three passes through the registered-read memories.
// After reset a clearing pass zeroes every memory row, with s_tready low.
// When the receiver stalls, the result waits in the output register and the
// next instruction holds in its final pass, so nothing is lost or reordered.
// ----------------------------------------------------------------------------
module x86_16bit_execute_subset_unit
	import x86ex_pkg::*;
#(
	parameter int MEM_BYTES = DEFAULT_MEM_BYTES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// op, dst_kind, dst_reg, src_kind, src_reg, imm_value, base_term,
	// index_term, disp_value, instr_length
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// next_ip, result_value, jump_taken, zero_flag, sign_flag, parity_flag,
	// then four zero bits
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int BANK_DEPTH = (MEM_BYTES + 1) / 2;
	localparam int ROW_W      = $clog2(BANK_DEPTH);
	localparam logic [ROW_W-1:0] CLR_LAST = ROW_W'(BANK_DEPTH - 1);
	localparam logic [ROW_W-1:0] NUM_REGS = ROW_W'(8);
	localparam logic [18:0] ADDR_MAX = 19'(MEM_BYTES - 2);

	state_t state_q, state_d;

	item_t  pend_q, cur_q;
	logic   pend_valid_q;
	logic   accept, load_cur, complete, out_free;

	logic [ROW_W-1:0] clr_q;

	logic [15:0] ip_q;
	logic        zf_q, sf_q, pf_q;

	logic             m_tvalid_q;
	result_t          m_result_q;

	// Register file ports.
	logic        rf_we;
	logic [2:0]  rf_waddr;
	logic [15:0] rf_wdata;
	logic [2:0]  rf_a_raddr, rf_b_raddr;
	logic [15:0] rf_a_rdata, rf_b_rdata;

	// Data memory bank ports.
	logic             ev_we, od_we;
	logic [ROW_W-1:0] ev_waddr, od_waddr, ev_raddr, od_raddr;
	logic [7:0]       ev_wdata, od_wdata, ev_rdata, od_rdata;

	// Address computation.
	logic [3:0]       base_m1, index_m1;
	logic             base_use, index_use;
	logic [18:0]      addr_sum;
	logic             addr_ok_c;
	logic [16:0]      addr_p1;
	logic [ROW_W-1:0] ev_row_c, od_row_c;
	logic             addr_ok_q, addr_odd_q;
	logic [ROW_W-1:0] ev_row_q, od_row_q;

	// Execution.
	logic [15:0] mem_word, dv, sv, res, ip_len, ip_new;
	logic        taken, wr_dst, set_fl;

	// ------------------------------------------------------------------
	// Input handshake: one instruction buffered while another executes.
	// ------------------------------------------------------------------
	assign s_tready = !pend_valid_q && (state_q != ST_CLEAR);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign complete = (state_q == ST_EXEC) && out_free;
	assign load_cur = pend_valid_q && ((state_q == ST_IDLE) || complete);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (accept) begin
			pend_valid_q <= 1'b1;
		end else if (load_cur) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_q <= item_t'(s_tdata);
		end
		if (load_cur) begin
			cur_q <= pend_q;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer state register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: clear, then three passes per instruction.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (pend_valid_q) begin
					state_d = ST_ADDR;
				end
			end
			ST_ADDR: state_d = ST_OPER;
			ST_OPER: state_d = ST_EXEC;
			ST_EXEC: begin
				if (complete) begin
					state_d = pend_valid_q ? ST_ADDR : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Clearing pass counter over the bank rows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_q <= clr_q + ROW_W'(1);
		end
	end

	// ------------------------------------------------------------------
	// Register file reads: address terms first, then the operands.
	// ------------------------------------------------------------------
	assign base_m1  = cur_q.base_term - 4'd1;
	assign index_m1 = cur_q.index_term - 4'd1;

	always_comb begin
		if (state_q == ST_ADDR) begin
			rf_a_raddr = base_m1[2:0];
			rf_b_raddr = index_m1[2:0];
		end else begin
			rf_a_raddr = cur_q.dst_reg;
			rf_b_raddr = cur_q.src_reg;
		end
	end

	// ------------------------------------------------------------------
	// Memory address: displacement plus up to two register terms.
	// ------------------------------------------------------------------
	assign base_use  = (cur_q.base_term != 4'd0) && (cur_q.base_term <= 4'd8);
	assign index_use = (cur_q.index_term != 4'd0) && (cur_q.index_term <= 4'd8);

	assign addr_sum = {{3{cur_q.disp_value[15]}}, cur_q.disp_value}
		+ {3'b000, (base_use ? rf_a_rdata : 16'h0000)}
		+ {3'b000, (index_use ? rf_b_rdata : 16'h0000)};
	assign addr_ok_c = !addr_sum[18] && (addr_sum <= ADDR_MAX);
	assign addr_p1   = {1'b0, addr_sum[15:0]} + 17'd1;
	assign ev_row_c  = addr_p1[ROW_W:1];
	assign od_row_c  = addr_sum[ROW_W:1];

	// Hold the address for the write-back pass.
	always_ff @(posedge clk) begin
		if (state_q == ST_OPER) begin
			addr_ok_q  <= addr_ok_c;
			addr_odd_q <= addr_sum[0];
			ev_row_q   <= ev_row_c;
			od_row_q   <= od_row_c;
		end
	end

	assign ev_raddr = (state_q == ST_EXEC) ? ev_row_q : ev_row_c;
	assign od_raddr = (state_q == ST_EXEC) ? od_row_q : od_row_c;

	// ------------------------------------------------------------------
	// Execute: operands, ALU, flags and the next IP.
	// ------------------------------------------------------------------
	always_comb begin
		if (!addr_ok_q) begin
			mem_word = 16'h0000;
		end else if (addr_odd_q) begin
			mem_word = {ev_rdata, od_rdata};
		end else begin
			mem_word = {od_rdata, ev_rdata};
		end
	end

	always_comb begin
		case (cur_q.dst_kind)
			KIND_REG: dv = rf_a_rdata;
			KIND_MEM: dv = mem_word;
			KIND_IMM: dv = cur_q.imm_value;
			default:  dv = 16'h0000;
		endcase
		case (cur_q.src_kind)
			KIND_REG: sv = rf_b_rdata;
			KIND_MEM: sv = mem_word;
			KIND_IMM: sv = cur_q.imm_value;
			default:  sv = 16'h0000;
		endcase
	end

	assign ip_len = ip_q + {13'b0, cur_q.instr_length};

	always_comb begin
		res    = 16'h0000;
		taken  = 1'b0;
		wr_dst = 1'b0;
		set_fl = 1'b0;
		ip_new = ip_len;
		case (cur_q.op)
			OP_MOV: begin
				res    = sv;
				wr_dst = 1'b1;
			end
			OP_ADD: begin
				res    = dv + sv;
				wr_dst = 1'b1;
				set_fl = 1'b1;
			end
			OP_SUB: begin
				res    = dv - sv;
				wr_dst = 1'b1;
				set_fl = 1'b1;
			end
			OP_CMP: begin
				res    = dv - sv;
				set_fl = 1'b1;
			end
			OP_JNE: begin
				if (!zf_q) begin
					taken  = 1'b1;
					ip_new = ip_len + cur_q.imm_value;
				end
			end
			default: begin
				res = 16'h0000;
			end
		endcase
	end

	// Architectural IP and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_q <= '0;
			zf_q <= 1'b0;
			sf_q <= 1'b0;
			pf_q <= 1'b0;
		end else if (complete) begin
			ip_q <= ip_new;
			if (set_fl) begin
				zf_q <= (res == 16'h0000);
				sf_q <= res[15];
				pf_q <= ~^res[7:0];
			end
		end
	end

	// ------------------------------------------------------------------
	// Write-back: the clearing pass or the destination of an instruction.
	// ------------------------------------------------------------------
	always_comb begin
		if (state_q == ST_CLEAR) begin
			rf_we    = (clr_q < NUM_REGS);
			rf_waddr = clr_q[2:0];
			rf_wdata = 16'h0000;
			ev_we    = 1'b1;
			od_we    = 1'b1;
			ev_waddr = clr_q;
			od_waddr = clr_q;
			ev_wdata = 8'h00;
			od_wdata = 8'h00;
		end else begin
			rf_we    = complete && wr_dst && (cur_q.dst_kind == KIND_REG);
			rf_waddr = cur_q.dst_reg;
			rf_wdata = res;
			ev_we    = complete && wr_dst && (cur_q.dst_kind == KIND_MEM) && addr_ok_q;
			od_we    = ev_we;
			ev_waddr = ev_row_q;
			od_waddr = od_row_q;
			ev_wdata = addr_odd_q ? res[15:8] : res[7:0];
			od_wdata = addr_odd_q ? res[7:0] : res[15:8];
		end
	end

	// Two copies of the register file give two read ports.
	x86ex_ram #(.WIDTH(16), .DEPTH(8)) u_rf_a (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.raddr (rf_a_raddr),
		.rdata (rf_a_rdata)
	);

	x86ex_ram #(.WIDTH(16), .DEPTH(8)) u_rf_b (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.raddr (rf_b_raddr),
		.rdata (rf_b_rdata)
	);

	// Even and odd byte banks of the data memory.
	x86ex_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_mem_even (
		.clk   (clk),
		.we    (ev_we),
		.waddr (ev_waddr),
		.wdata (ev_wdata),
		.raddr (ev_raddr),
		.rdata (ev_rdata)
	);

	x86ex_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_mem_odd (
		.clk   (clk),
		.we    (od_we),
		.waddr (od_waddr),
		.wdata (od_wdata),
		.raddr (od_raddr),
		.rdata (od_rdata)
	);

	// ------------------------------------------------------------------
	// Output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (complete) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (complete) begin
			m_result_q.next_ip      <= ip_new;
			m_result_q.result_value <= res;
			m_result_q.jump_taken   <= taken;
			m_result_q.zero_flag    <= set_fl ? (res == 16'h0000) : zf_q;
			m_result_q.sign_flag    <= set_fl ? res[15] : sf_q;
			m_result_q.parity_flag  <= set_fl ? ~^res[7:0] : pf_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, m_result_q};

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the 16-bit x86 execute subset unit
// Sends decoded mov, add, sub, cmp and jne instructions over the input stream,
// predicts registers, flags, IP and the byte memory in step with every accepted
// transaction, and checks each returned result field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
	import x86ex_pkg::*;

	localparam int MEM_BYTES   = DEFAULT_MEM_BYTES;
	localparam int STALL_LIMIT = 100000;

	// Opcodes outside the enum that must act like OP_NOP.
	localparam logic [2:0] OP_UNDEF_A = 3'd6;
	localparam logic [2:0] OP_UNDEF_B = 3'd7;

	// Register numbers and the matching address term codes.
	localparam logic [2:0] AX = 3'd0, BX = 3'd1, CX = 3'd2, DX = 3'd3;
	localparam logic [2:0] SP = 3'd4, BP = 3'd5, SI = 3'd6, DI = 3'd7;
	localparam logic [3:0] TERM_NONE = 4'd0, TERM_SI = 4'd7, TERM_DI = 4'd8;
	localparam logic [3:0] TERM_UNUSED_LO = 4'd9, TERM_UNUSED_HI = 4'd15;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	// Shadow state of the execute unit.
	logic [15:0] cpu_regs [8];
	logic [15:0] cpu_ip;
	logic        cpu_zf, cpu_sf, cpu_pf;
	logic [7:0]  cpu_mem [0:MEM_BYTES-1];

	result_t pending_results [$];
	int      mismatch_count = 0;
	int      quiet_cycles = 0;
	bit      idle_on;

	x86_16bit_execute_subset_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Clock with a 2 ns period.
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Instruction predictor
	// ------------------------------------------------------------------------

	// Memory operand address: signed displacement plus up to two register terms.
	function automatic int operand_address(item_t it);
		int addr;
		addr = $signed(it.disp_value);
		if (it.base_term >= 4'd1 && it.base_term <= 4'd8)
			addr += int'(cpu_regs[3'(it.base_term - 4'd1)]);
		if (it.index_term >= 4'd1 && it.index_term <= 4'd8)
			addr += int'(cpu_regs[3'(it.index_term - 4'd1)]);
		return addr;
	endfunction

	function automatic bit word_in_range(int addr);
		return addr >= 0 && addr <= MEM_BYTES - 2;
	endfunction

	function automatic logic [15:0] fetch_operand(logic [1:0] kind, logic [2:0] rnum, item_t it);
		int addr;
		case (kind)
			KIND_REG: return cpu_regs[rnum];
			KIND_IMM: return it.imm_value;
			KIND_MEM: begin
				addr = operand_address(it);
				if (!word_in_range(addr))
					return 16'h0000;
				return {cpu_mem[16'(addr + 1)], cpu_mem[16'(addr)]};
			end
			default: return 16'h0000;
		endcase
	endfunction

	// Writes to none and immediate destinations are dropped.
	function automatic void store_operand(logic [1:0] kind, logic [2:0] rnum, item_t it,
			logic [15:0] value);
		int addr;
		if (kind == KIND_REG) begin
			cpu_regs[rnum] = value;
		end else if (kind == KIND_MEM) begin
			addr = operand_address(it);
			if (word_in_range(addr)) begin
				cpu_mem[16'(addr)]     = value[7:0];
				cpu_mem[16'(addr + 1)] = value[15:8];
			end
		end
	endfunction

	// Executes one instruction on the shadow state and returns its result.
	function automatic result_t execute_instr(item_t it);
		result_t     res;
		logic [15:0] dst_val, src_val, value;
		logic        taken;
		value  = 16'h0000;
		taken  = 1'b0;
		cpu_ip = cpu_ip + 16'(it.instr_length);
		case (it.op)
			OP_MOV: begin
				value = fetch_operand(it.src_kind, it.src_reg, it);
				store_operand(it.dst_kind, it.dst_reg, it, value);
			end
			OP_ADD, OP_SUB, OP_CMP: begin
				dst_val = fetch_operand(it.dst_kind, it.dst_reg, it);
				src_val = fetch_operand(it.src_kind, it.src_reg, it);
				value   = (it.op == OP_ADD) ? dst_val + src_val : dst_val - src_val;
				if (it.op != OP_CMP)
					store_operand(it.dst_kind, it.dst_reg, it, value);
				cpu_zf = (value == 16'h0000);
				cpu_sf = value[15];
				cpu_pf = ~^value[7:0];
			end
			OP_JNE: begin
				if (!cpu_zf) begin
					cpu_ip = cpu_ip + it.imm_value;
					taken  = 1'b1;
				end
			end
			default: ;
		endcase
		res.next_ip      = cpu_ip;
		res.result_value = value;
		res.jump_taken   = taken;
		res.zero_flag    = cpu_zf;
		res.sign_flag    = cpu_sf;
		res.parity_flag  = cpu_pf;
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Instruction builders
	// ------------------------------------------------------------------------

	function automatic item_t make_instr(logic [2:0] op, logic [1:0] dk, logic [2:0] dr,
			logic [1:0] sk, logic [2:0] sr, logic [15:0] imm, logic [3:0] bt,
			logic [3:0] xt, logic [15:0] disp, logic [2:0] len);
		item_t it;
		it.op           = op;
		it.dst_kind     = dk;
		it.dst_reg      = dr;
		it.src_kind     = sk;
		it.src_reg      = sr;
		it.imm_value    = imm;
		it.base_term    = bt;
		it.index_term   = xt;
		it.disp_value   = disp;
		it.instr_length = len;
		return it;
	endfunction

	function automatic logic [1:0] rand_kind();
		int pick;
		pick = $urandom_range(99);
		if (pick < 40)
			return KIND_REG;
		if (pick < 70)
			return KIND_MEM;
		if (pick < 90)
			return KIND_IMM;
		return KIND_NONE;
	endfunction

	function automatic logic [15:0] rand_imm();
		int pick;
		pick = $urandom_range(99);
		if (pick < 45)
			return 16'($urandom_range(15));
		if (pick < 75)
			return 16'($urandom);
		case ($urandom_range(4))
			0: return 16'h0000;
			1: return 16'h0001;
			2: return 16'h7FFF;
			3: return 16'h8000;
			default: return 16'hFFFF;
		endcase
	endfunction

	function automatic logic [3:0] window_term();
		return $urandom_range(1) ? TERM_NONE : 4'($urandom_range(15, 9));
	endfunction

	// A plausible program step: memory traffic mostly stays in a small window
	// so that stored words are read back, and sub/cmp often compare an operand
	// with itself so that jne sees both states of the zero flag.
	function automatic item_t program_instr();
		logic [2:0]  op, dr, sr, len;
		logic [1:0]  dk, sk;
		logic [3:0]  bt, xt;
		logic [15:0] disp;
		int          pick;
		pick = $urandom_range(99);
		if (pick < 25)      op = OP_MOV;
		else if (pick < 43) op = OP_ADD;
		else if (pick < 58) op = OP_SUB;
		else if (pick < 73) op = OP_CMP;
		else if (pick < 90) op = OP_JNE;
		else if (pick < 96) op = OP_NOP;
		else if (pick < 98) op = OP_UNDEF_A;
		else                op = OP_UNDEF_B;
		dk = rand_kind();
		sk = rand_kind();
		dr = 3'($urandom_range(7));
		sr = 3'($urandom_range(7));
		if ((op == OP_SUB || op == OP_CMP) && $urandom_range(3) == 0) begin
			sk = dk;
			sr = dr;
		end
		pick = $urandom_range(99);
		if (pick < 55) begin
			bt   = window_term();
			xt   = window_term();
			disp = 16'($urandom_range(255));
		end else if (pick < 80) begin
			bt   = 4'($urandom_range(15));
			xt   = 4'($urandom_range(15));
			disp = 16'($urandom);
		end else begin
			bt   = 4'($urandom_range(8, 1));
			xt   = TERM_NONE;
			disp = 16'($urandom_range(16)) - 16'd8;
		end
		if ($urandom_range(19) == 0)
			len = $urandom_range(1) ? 3'd0 : 3'd7;
		else
			len = 3'($urandom_range(6, 1));
		return make_instr(op, dk, dr, sk, sr, rand_imm(), bt, xt, disp, len);
	endfunction

	function automatic item_t noise_instr();
		logic [63:0] bits;
		bits = {$urandom, $urandom};
		return bits[IN_TDATA_W-1:0];
	endfunction

	// ------------------------------------------------------------------------
	// Stream driving
	// ------------------------------------------------------------------------

	// Called at a falling edge; returns at the falling edge after acceptance
	// with tvalid still high, so the next call may keep it high.
	task automatic send_instr(input item_t it);
		if (idle_on) begin
			while ($urandom_range(99) < 37) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata  <= it;
		do
			@(posedge clk);
		while (!s_tready);
		pending_results.push_back(execute_instr(it));
		@(negedge clk);
	endtask

	// Holds the input stream idle until every expected result has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	// Receiver backpressure.
	always @(negedge clk) begin
		m_tready <= idle_on ? ($urandom_range(99) >= 37) : 1'b1;
	end

	// ------------------------------------------------------------------------
	// Test tasks
	// ------------------------------------------------------------------------

	// Field extremes, every operation and the corner cases of addressing.
	task automatic test_directed();
		idle_on = 1'b1;
		send_instr(make_instr(OP_MOV, KIND_REG, AX, KIND_IMM, AX, 16'hFFFF, TERM_NONE,
			TERM_NONE, 16'h0000, 3'd3));
		// Wraps to zero: zero and parity set.
		send_instr(make_instr(OP_ADD, KIND_REG, AX, KIND_IMM, AX, 16'h0001, TERM_NONE,
			TERM_NONE, 16'h0000, 3'd3));
		send_instr(make_instr(OP_JNE, KIND_NONE, AX, KIND_NONE, AX, 16'h0010, TERM_NONE,
			TERM_NONE, 16'h0000, 3'd2));
		send_instr(make_instr(OP_SUB, KIND_REG, AX, KIND_IMM, AX, 16'h0001, TERM_NONE,
			TERM_NONE, 16'h0000, 3'd3));
		// Taken jump with a backward displacement that wraps the IP.
		send_instr(make_instr(OP_JNE, KIND_NONE, AX, KIND_NONE, AX, 16'hFFF0, TERM_NONE,
			TERM_NONE, 16'h0000, 3'd2));
		send_instr(make_instr(OP_MOV, KIND_MEM, AX, KIND_REG, AX, 16'h0000, TERM_NONE,
			TERM_NONE, 16'h0100, 3'd4));
		send_instr(make_instr(OP_MOV, KIND_REG, CX, KIND_MEM, AX, 16'h0000, TERM_NONE,
			TERM_NONE, 16'h0100, 3'd4));
		// Both operands in memory share one address.
		send_instr(make_instr(OP_ADD, KIND_MEM, AX, KIND_MEM, AX, 16'h0000, TERM_NONE,
			TERM_NONE, 16'h0100, 3'd4));
		send_instr(make_instr(OP_MOV, KIND_REG, SI, KIND_IMM, AX, 16'hFFFF, TERM_NONE,
			TERM_NONE, 16'h0000, 3'd3));
		// Word at 65535 is out of range; the one at 65534 is the last valid word.
		send_instr(make_instr(OP_MOV, KIND_MEM, AX, KIND_REG, CX, 16'h0000, TERM_SI,
			TERM_NONE, 16'h0000, 3'd4));
		send_instr(make_instr(OP_MOV, KIND_MEM, AX, KIND_REG, CX, 16'h0000, TERM_SI,
			TERM_NONE, 16'hFFFF, 3'd4));
		send_instr(make_instr(OP_MOV, KIND_REG, DX, KIND_MEM, AX, 16'h0000, TERM_SI,
			TERM_NONE, 16'hFFFF, 3'd4));
		send_instr(make_instr(OP_MOV, KIND_REG, BX, KIND_MEM, AX, 16'h0000, TERM_SI,
			TERM_NONE, 16'h0000, 3'd4));
		// Negative address reads zero.
		send_instr(make_instr(OP_MOV, KIND_REG, DI, KIND_MEM, AX, 16'h0000, TERM_NONE,
			TERM_NONE, 16'h8000, 3'd4));
		// Sum beyond the memory is dropped.
		send_instr(make_instr(OP_MOV, KIND_MEM, AX, KIND_REG, DX, 16'h0000, TERM_DI,
			TERM_SI, 16'h7FFF, 3'd5));
		// Unused term codes add nothing.
		send_instr(make_instr(OP_MOV, KIND_REG, BP, KIND_MEM, AX, 16'h0000, TERM_UNUSED_HI,
			TERM_UNUSED_LO, 16'h0100, 3'd4));
		// None and immediate destinations still update the flags.
		send_instr(make_instr(OP_ADD, KIND_NONE, AX, KIND_IMM, AX, 16'h0080, TERM_NONE,
			TERM_NONE, 16'h0000, 3'd3));
		send_instr(make_instr(OP_SUB, KIND_IMM, AX, KIND_REG, AX, 16'h8000, TERM_NONE,
			TERM_NONE, 16'h0000, 3'd4));
		send_instr(make_instr(OP_CMP, KIND_REG, CX, KIND_REG, CX, 16'h0000, TERM_NONE,
			TERM_NONE, 16'h0000, 3'd2));
		send_instr(make_instr(OP_JNE, KIND_NONE, AX, KIND_NONE, AX, 16'h1234, TERM_NONE,
			TERM_NONE, 16'h0000, 3'd2));
		send_instr(make_instr(OP_CMP, KIND_REG, AX, KIND_IMM, AX, 16'h0000, TERM_NONE,
			TERM_NONE, 16'h0000, 3'd3));
		send_instr(make_instr(OP_JNE, KIND_NONE, AX, KIND_NONE, AX, 16'h1234, TERM_NONE,
			TERM_NONE, 16'h0000, 3'd2));
		// The no-op and undefined opcodes, with odd lengths, only move the IP.
		send_instr(make_instr(OP_NOP, KIND_REG, AX, KIND_IMM, AX, 16'hFFFF, TERM_NONE,
			TERM_NONE, 16'h0000, 3'd6));
		send_instr(make_instr(OP_UNDEF_A, KIND_REG, AX, KIND_IMM, AX, 16'hFFFF, TERM_NONE,
			TERM_NONE, 16'h0000, 3'd0));
		send_instr(make_instr(OP_UNDEF_B, KIND_REG, AX, KIND_IMM, AX, 16'hFFFF, TERM_NONE,
			TERM_NONE, 16'h0000, 3'd7));
		send_instr(make_instr(OP_MOV, KIND_NONE, AX, KIND_REG, AX, 16'h0000, TERM_NONE,
			TERM_NONE, 16'h0000, 3'd1));
		send_instr(make_instr(OP_ADD, KIND_REG, SP, KIND_IMM, AX, 16'h7FFF, TERM_NONE,
			TERM_NONE, 16'h0000, 3'd3));
		wait_drained();
	endtask

	// Random program steps with random gaps and stalls.
	task automatic test_program_mix(input int count);
		idle_on = 1'b1;
		repeat (count)
			send_instr(program_instr());
	endtask

	// Program steps with no gaps on either side, at the full rate.
	task automatic test_back_to_back(input int count);
		idle_on = 1'b0;
		repeat (count)
			send_instr(program_instr());
		idle_on = 1'b1;
	endtask

	// Fully random instruction bits.
	task automatic test_noise(input int count);
		idle_on = 1'b1;
		repeat (count)
			send_instr(noise_instr());
	endtask

	// ------------------------------------------------------------------------
	// Result checking and watchdog
	// ------------------------------------------------------------------------

	function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		result_t got, want;
		if (m_tvalid && m_tready) begin
			got = m_tdata[RESULT_W-1:0];
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none actual %h", $time, got);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("next_ip", want.next_ip, got.next_ip);
				check_field("result_value", want.result_value, got.result_value);
				check_field("jump_taken", 16'(want.jump_taken), 16'(got.jump_taken));
				check_field("zero_flag", 16'(want.zero_flag), 16'(got.zero_flag));
				check_field("sign_flag", 16'(want.sign_flag), 16'(got.sign_flag));
				check_field("parity_flag", 16'(want.parity_flag), 16'(got.parity_flag));
			end
		end
		// The limit covers the clearing pass after reset.
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------

	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		idle_on        = 1'b1;
		cpu_ip         = 16'h0000;
		cpu_zf         = 1'b0;
		cpu_sf         = 1'b0;
		cpu_pf         = 1'b0;
		foreach (cpu_regs[i])
			cpu_regs[i] = 16'h0000;
		foreach (cpu_mem[i])
			cpu_mem[i] = 8'h00;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_program_mix(700);
		test_back_to_back(350);
		test_program_mix(550);
		test_noise(280);

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

FILE: sim.f
hdl/x86ex_pkg.sv
hdl/x86ex_ram.sv
hdl/x86_16bit_execute_subset_unit.sv
tb/tb.sv
